// ===== rtl/acm_pkg.sv =====
// Shared types and constants of the autoranging current monitor.
package acm_pkg;

  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_READ_INTERVAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_SCALE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_ALPHA  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPIKE_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SWITCH_UP     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SWITCH_DOWN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ERRORS    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY         = 3'd7;

  localparam logic [15:0] RST_READ_INTERVAL = 16'd500;
  localparam logic [24:0] RST_CURRENT_SCALE = 25'd819200;
  localparam logic [16:0] RST_SMOOTH_ALPHA  = 17'd16384;
  localparam logic [22:0] RST_SPIKE_LIMIT   = 23'd200000;
  localparam logic [22:0] RST_SWITCH_UP     = 23'd100000;
  localparam logic [22:0] RST_SWITCH_DOWN   = 23'd90000;
  localparam logic [7:0]  RST_MAX_ERRORS    = 8'd5;
  localparam logic [31:0] RST_RETRY         = 32'd30000;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BUS_ERR  = 2'd1;
  localparam logic [1:0] STATUS_COOLDOWN = 2'd2;
  localparam logic [1:0] STATUS_RANGE    = 2'd3;

  localparam logic [15:0] SAT_SHUNT_LIMIT = 16'd7800;
  localparam logic [12:0] BUS_OVERFLOW    = 13'h1FFF;
  localparam logic [16:0] ALPHA_ONE       = 17'h10000;
  localparam logic [7:0]  ERR_MAX         = 8'hFF;
  localparam logic [23:0] CUR_MAX         = 24'h7FFFFF;
  localparam logic [23:0] CUR_MIN         = 24'h800000;

  typedef struct packed {
    logic load;
    logic check;
    logic raw;
    logic mul;
    logic sum;
    logic pwr;
    logic emit;
  } acm_cmd_t;

  typedef struct packed {
    logic proceed;
    logic spike;
    logic seeded;
  } acm_sts_t;

endpackage

// ===== rtl/acm_ctrl.sv =====
// Sequencer of the autoranging current monitor: steps one word through the datapath.
module acm_ctrl
  import acm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  acm_sts_t sts,
  output acm_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_RAW,
    S_MUL,
    S_SUM,
    S_PWR,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = sts.proceed ? S_RAW : S_OUT;
      end
      S_RAW: begin
        cmd.raw = 1'b1;
        if (sts.spike) state_nxt = S_OUT;
        else if (sts.seeded) state_nxt = S_MUL;
        else state_nxt = S_PWR;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_PWR;
      end
      S_PWR: begin
        cmd.pwr   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        cmd.emit = out_free;
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.emit) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/acm_dp.sv =====
// Datapath of the autoranging current monitor: settings, tracking state, arithmetic, result word.
module acm_dp
  import acm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_read_ok,
  input  logic signed [15:0]   in_shunt_raw,
  input  logic [15:0]          in_bus_raw,
  input  logic [31:0]          in_now_ms,
  input  acm_cmd_t             cmd,
  output acm_sts_t             sts,
  output logic [1:0]           out_status,
  output logic                 out_updated,
  output logic signed [15:0]   out_shunt_value,
  output logic [14:0]          out_bus_mv,
  output logic signed [23:0]   out_current_ma,
  output logic signed [38:0]   out_power_uw,
  output logic [31:0]          out_sample_time_ms,
  output logic                 out_range_wide,
  output logic                 out_range_write,
  output logic                 out_bus_recover
);

  logic [15:0]        read_interval_r;
  logic signed [24:0] scale_r;
  logic [16:0]        alpha_r;
  logic [22:0]        spike_limit_r;
  logic [22:0]        switch_up_r;
  logic [22:0]        switch_down_r;
  logic [7:0]         max_errors_r;
  logic [31:0]        retry_r;

  logic               wide_r;
  logic signed [23:0] ema_r;
  logic               seeded_r;
  logic [7:0]         err_cnt_r;
  logic [31:0]        retry_at_r;
  logic [31:0]        last_read_r;
  logic [1:0]         status_r;
  logic signed [15:0] held_shunt_r;
  logic [14:0]        held_bus_mv_r;
  logic signed [38:0] held_power_r;
  logic [31:0]        held_time_r;
  logic               upd_r;
  logic               rw_r;
  logic               rec_r;

  logic               ok_r;
  logic signed [15:0] shunt_r;
  logic [14:0]        mv_r;
  logic [31:0]        now_r;
  logic signed [40:0] prod_r;
  logic signed [23:0] raw_r;
  logic signed [41:0] p_old_r;
  logic signed [41:0] p_new_r;

  logic [12:0]        bus_field;
  logic [14:0]        bus_mv_in;
  logic               cool_on;
  logic               in_cool;
  logic [31:0]        dt;
  logic               too_soon;
  logic [7:0]         err_base;
  logic [7:0]         err_inc;
  logic [15:0]        abs_shunt;
  logic               sat;

  logic signed [40:0] prod_rnd;
  logic signed [24:0] raw_wide;
  logic signed [23:0] raw_cl;
  logic [23:0]        abs_raw;
  logic               spike;

  logic [16:0]        alpha_eff;
  logic [16:0]        alpha_rest;
  logic signed [42:0] sum_rnd;
  logic signed [26:0] ema_wide;
  logic signed [23:0] ema_cl;
  logic signed [39:0] pwr_full;

  assign bus_field = in_bus_raw[15:3];
  assign bus_mv_in = (bus_field == BUS_OVERFLOW) ? 15'd0 : {bus_field, 2'b00};

  assign cool_on   = (retry_at_r != 32'd0);
  assign in_cool   = cool_on && (now_r < retry_at_r);
  assign dt        = now_r - last_read_r;
  assign too_soon  = dt < {16'd0, read_interval_r};
  assign err_base  = cool_on ? 8'd0 : err_cnt_r;
  assign err_inc   = (err_base != ERR_MAX) ? err_base + 8'd1 : err_base;
  assign abs_shunt = shunt_r[15] ? (~shunt_r + 16'd1) : shunt_r;
  assign sat       = !wide_r && (abs_shunt > SAT_SHUNT_LIMIT);

  assign prod_rnd = prod_r + 41'sd32768;
  assign raw_wide = prod_rnd[40:16];
  always_comb begin
    if (raw_wide[24] != raw_wide[23]) raw_cl = raw_wide[24] ? CUR_MIN : CUR_MAX;
    else raw_cl = raw_wide[23:0];
  end
  assign abs_raw = raw_cl[23] ? (~raw_cl + 24'd1) : raw_cl;
  assign spike   = abs_raw > {1'b0, spike_limit_r};

  assign alpha_eff  = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;
  assign alpha_rest = ALPHA_ONE - alpha_eff;

  assign sum_rnd  = 43'(p_old_r) + 43'(p_new_r) + 43'sd32768;
  assign ema_wide = sum_rnd[42:16];
  always_comb begin
    if (!((&ema_wide[26:23]) || !(|ema_wide[26:23])))
      ema_cl = ema_wide[26] ? CUR_MIN : CUR_MAX;
    else
      ema_cl = ema_wide[23:0];
  end

  assign pwr_full = $signed({1'b0, held_bus_mv_r}) * ema_r;

  assign sts.proceed = !in_cool && !too_soon && ok_r && !sat;
  assign sts.spike   = spike;
  assign sts.seeded  = seeded_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_interval_r <= RST_READ_INTERVAL;
      scale_r         <= RST_CURRENT_SCALE;
      alpha_r         <= RST_SMOOTH_ALPHA;
      spike_limit_r   <= RST_SPIKE_LIMIT;
      switch_up_r     <= RST_SWITCH_UP;
      switch_down_r   <= RST_SWITCH_DOWN;
      max_errors_r    <= RST_MAX_ERRORS;
      retry_r         <= RST_RETRY;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_READ_INTERVAL: read_interval_r <= cfg_data[15:0];
        REG_CURRENT_SCALE: scale_r         <= cfg_data[24:0];
        REG_SMOOTH_ALPHA:  alpha_r         <= cfg_data[16:0];
        REG_SPIKE_LIMIT:   spike_limit_r   <= cfg_data[22:0];
        REG_SWITCH_UP:     switch_up_r     <= cfg_data[22:0];
        REG_SWITCH_DOWN:   switch_down_r   <= cfg_data[22:0];
        REG_MAX_ERRORS:    max_errors_r    <= cfg_data[7:0];
        REG_RETRY:         retry_r         <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_r        <= 1'b0;
      ema_r         <= '0;
      seeded_r      <= 1'b0;
      err_cnt_r     <= '0;
      retry_at_r    <= '0;
      last_read_r   <= '0;
      status_r      <= STATUS_OK;
      held_shunt_r  <= '0;
      held_bus_mv_r <= '0;
      held_power_r  <= '0;
      held_time_r   <= '0;
      upd_r         <= 1'b0;
      rw_r          <= 1'b0;
      rec_r         <= 1'b0;
    end else begin
      if (cmd.load) begin
        upd_r <= 1'b0;
        rw_r  <= 1'b0;
        rec_r <= 1'b0;
      end
      if (cmd.check) begin
        if (in_cool) begin
          status_r <= STATUS_COOLDOWN;
        end else if (too_soon) begin
          retry_at_r <= '0;
          err_cnt_r  <= err_base;
        end else begin
          last_read_r <= now_r;
          if (!ok_r) begin
            status_r   <= STATUS_BUS_ERR;
            rec_r      <= 1'b1;
            err_cnt_r  <= err_inc;
            retry_at_r <= (err_inc >= max_errors_r) ? now_r + retry_r : 32'd0;
          end else begin
            retry_at_r <= '0;
            err_cnt_r  <= '0;
            if (sat) begin
              wide_r   <= 1'b1;
              rw_r     <= 1'b1;
              status_r <= STATUS_RANGE;
            end
          end
        end
      end
      if (cmd.raw) begin
        if (spike) begin
          status_r <= STATUS_RANGE;
        end else begin
          if (!seeded_r) begin
            ema_r    <= raw_cl;
            seeded_r <= 1'b1;
          end
          held_shunt_r  <= shunt_r;
          held_bus_mv_r <= mv_r;
          held_time_r   <= now_r;
          status_r      <= STATUS_OK;
          upd_r         <= 1'b1;
          if (!wide_r && (abs_raw >= {1'b0, switch_up_r})) begin
            wide_r <= 1'b1;
            rw_r   <= 1'b1;
          end else if (wide_r && (abs_raw < {1'b0, switch_down_r})) begin
            wide_r <= 1'b0;
            rw_r   <= 1'b1;
          end
        end
      end
      if (cmd.sum) ema_r <= ema_cl;
      if (cmd.pwr) held_power_r <= pwr_full[38:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ok_r    <= in_read_ok;
      shunt_r <= in_shunt_raw;
      mv_r    <= bus_mv_in;
      now_r   <= in_now_ms;
    end
    if (cmd.check) prod_r <= shunt_r * scale_r;
    if (cmd.raw) raw_r <= raw_cl;
    if (cmd.mul) begin
      p_old_r <= ema_r * $signed({1'b0, alpha_rest});
      p_new_r <= raw_r * $signed({1'b0, alpha_eff});
    end
    if (cmd.emit) begin
      out_status         <= status_r;
      out_updated        <= upd_r;
      out_shunt_value    <= held_shunt_r;
      out_bus_mv         <= held_bus_mv_r;
      out_current_ma     <= ema_r;
      out_power_uw       <= held_power_r;
      out_sample_time_ms <= held_time_r;
      out_range_wide     <= wide_r;
      out_range_write    <= rw_r;
      out_bus_recover    <= rec_r;
    end
  end

endmodule

// ===== rtl/autoranging_current_monitor.sv =====
// Autoranging current monitor: read attempts in, held readings and range requests out.
//
// Each input word is one read attempt (read_ok, shunt_raw, bus_raw, now_ms); every
// accepted word yields exactly one result word with the held reading, the range
// state and the range-write and bus-recover requests. Both channels move a word
// at a clock edge with valid high and stall low.
// A word runs through the sequencer one step per cycle, but emit waits for a free
// output register: check, raw current, EMA multiply, EMA sum, power, emit. A
// cooldown, early, bus-error or saturated word goes from check to emit, a spike
// from raw current to emit, and the first sample that seeds the EMA skips the EMA
// multiply and sum. The next word is taken only the cycle after emit; the steps are
// set by the chained multiplies of raw current, EMA and power on the one datapath.
// The result sits in an output register, so a stalled receiver holds it while
// the next word is accepted and processed; emit waits until the register frees.
// Write settings registers via cfg_we/cfg_idx/cfg_data only while idle; not enforced.
// Synchronous reset (rst_n low) loads the default settings, narrow range, an
// unseeded EMA, no cooldown, zeroed held reading, and drops any pending result.
module autoranging_current_monitor
  import acm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_read_ok,
  input  logic signed [15:0]   in_shunt_raw,
  input  logic [15:0]          in_bus_raw,
  input  logic [31:0]          in_now_ms,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_status,
  output logic                 out_updated,
  output logic signed [15:0]   out_shunt_value,
  output logic [14:0]          out_bus_mv,
  output logic signed [23:0]   out_current_ma,
  output logic signed [38:0]   out_power_uw,
  output logic [31:0]          out_sample_time_ms,
  output logic                 out_range_wide,
  output logic                 out_range_write,
  output logic                 out_bus_recover
);

  acm_cmd_t cmd;
  acm_sts_t sts;

  acm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  acm_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_idx            (cfg_idx),
    .cfg_data           (cfg_data),
    .in_read_ok         (in_read_ok),
    .in_shunt_raw       (in_shunt_raw),
    .in_bus_raw         (in_bus_raw),
    .in_now_ms          (in_now_ms),
    .cmd                (cmd),
    .sts                (sts),
    .out_status         (out_status),
    .out_updated        (out_updated),
    .out_shunt_value    (out_shunt_value),
    .out_bus_mv         (out_bus_mv),
    .out_current_ma     (out_current_ma),
    .out_power_uw       (out_power_uw),
    .out_sample_time_ms (out_sample_time_ms),
    .out_range_wide     (out_range_wide),
    .out_range_write    (out_range_write),
    .out_bus_recover    (out_bus_recover)
  );

endmodule
